// ===== design/h264fu_pkg.sv =====
`timescale 1ns / 1ps

package h264fu_pkg;

  localparam int FRAME_SIZE_BITS = 24;
  localparam int TOTAL_W         = FRAME_SIZE_BITS + 1;
  localparam int LEN_W           = 14;
  localparam int FILL_W          = 13;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 14'd1400;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_MIN   = 14'd3;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_MAX   = 14'd8192;

  localparam logic [7:0] NRI_MASK   = 8'hE0;
  localparam logic [7:0] FU_A_TYPE  = 8'd28;
  localparam logic [7:0] START_BIT  = 8'h80;
  localparam logic [7:0] TYPE_MASK  = 8'h1F;
  localparam logic [7:0] END_BIT    = 8'h40;
  localparam logic [7:0] START_KEEP = 8'h7F;

  localparam logic [FILL_W-1:0] FU_BYTES = 13'd2;

  typedef struct packed {
    logic [7:0]                 data_byte;
    logic                       first_of_frame;
    logic [FRAME_SIZE_BITS-1:0] frame_size;
    logic [7:0]                 channel;
    logic [7:0]                 frame_type;
    logic [31:0]                timestamp;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             packet_start;
    logic             packet_end;
    logic             frame_end;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       out_channel;
    logic [7:0]       out_type;
    logic [31:0]      out_timestamp;
  } out_item_t;

  // everything one input transaction produces: optional fu bytes, optional data byte
  typedef struct packed {
    logic             has_hdr;
    logic             has_data;
    logic [7:0]       fu_ind;
    logic [7:0]       fu_hdr;
    logic [7:0]       data;
    logic             data_start;
    logic             data_end;
    logic             frame_end;
    logic [LEN_W-1:0] len;
    logic [7:0]       channel;
    logic [7:0]       frame_type;
    logic [31:0]      timestamp;
  } entry_t;

endpackage

// ===== design/h264_fu_a_packetizer_core.sv =====
`timescale 1ns / 1ps

// h.264 fu-a packetizer: one nal unit byte in per transaction, payload bytes out.
// input channel: in_valid / in_stall with in_item; frame_size is read on the
//   byte that has first_of_frame set. output channel: out_valid / out_stall
//   with out_item, one payload byte per transaction.
// cfg_wr_en / cfg_wr_data write max_payload; write it only while the block is idle.
// a frame that fits in max_payload goes out as one packet. a larger frame has its
//   nal header byte replaced by fu indicator and fu header at the head of every
//   fragment, so an input byte yields 0 to 3 output bytes.
// path: an accepted byte is registered into the entry queue and then loaded into the
//   output register; a stalled output keeps it waiting in the queue.
// throughput: the front takes one byte per cycle while the entry queue has room;
//   the back sends one output byte per cycle while not stalled, so the extra fu
//   bytes are absorbed by the queue (QUEUE_DEPTH entries) before in_stall rises.
// reset: packetizer state cleared, queue and output emptied, max_payload = 1400.
// a stalled output holds its byte; the queue fills and then in_stall goes high.
module h264_fu_a_packetizer_core #(
  parameter int QUEUE_DEPTH = h264fu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  h264fu_pkg::in_item_t         in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output h264fu_pkg::out_item_t        out_item,
  input  logic                         cfg_wr_en,
  input  logic [h264fu_pkg::LEN_W-1:0] cfg_wr_data
);
  import h264fu_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_not_empty;
  logic   q_pop;
  entry_t q_entry;
  entry_t q_head;

  h264fu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  h264fu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head),
    .pop        (q_pop)
  );

  h264fu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// ===== design/h264fu_front.sv =====
`timescale 1ns / 1ps

module h264fu_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  h264fu_pkg::in_item_t           in_item,
  input  logic                           cfg_wr_en,
  input  logic [h264fu_pkg::LEN_W-1:0]   cfg_wr_data,
  input  logic                           q_full,
  output logic                           q_push,
  output h264fu_pkg::entry_t             q_entry
);
  import h264fu_pkg::*;

  logic [LEN_W-1:0]           max_payload;
  logic                       frag_mode;
  logic [FRAME_SIZE_BITS-1:0] bytes_left;
  logic [FILL_W-1:0]          packet_fill;
  logic [7:0]                 fu_indicator;
  logic [7:0]                 fu_header;

  logic [LEN_W-1:0]           limit;
  logic [TOTAL_W-1:0]         limit_tot;
  logic [FRAME_SIZE_BITS-1:0] fsize;
  logic                       accept;
  logic                       produce;
  logic                       frag_start;
  logic                       frag_eff;
  logic                       need_hdr;
  logic [FILL_W-1:0]          pf_eff;
  logic [FRAME_SIZE_BITS-1:0] bl_eff;
  logic [TOTAL_W-1:0]         total;
  logic                       last;
  logic [LEN_W-1:0]           len;
  logic                       pkt_end;
  logic [7:0]                 ind_val;
  logic [7:0]                 hdr_base;

  always_comb begin
    if (max_payload < MAX_PAYLOAD_MIN) begin
      limit = MAX_PAYLOAD_MIN;
    end else if (max_payload > MAX_PAYLOAD_MAX) begin
      limit = MAX_PAYLOAD_MAX;
    end else begin
      limit = max_payload;
    end
  end

  assign limit_tot = TOTAL_W'(limit);
  assign fsize     = (in_item.frame_size == '0) ? FRAME_SIZE_BITS'(1) : in_item.frame_size;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  // bytes past the frame end give nothing
  assign produce    = in_item.first_of_frame || (bytes_left != '0);
  assign frag_start = in_item.first_of_frame && (TOTAL_W'(fsize) > limit_tot);

  always_comb begin
    if (frag_start) begin
      frag_eff = 1'b1;
      need_hdr = 1'b1;
      pf_eff   = FU_BYTES;
      bl_eff   = fsize - FRAME_SIZE_BITS'(1);
    end else if (in_item.first_of_frame) begin
      frag_eff = 1'b0;
      need_hdr = 1'b0;
      pf_eff   = '0;
      bl_eff   = fsize;
    end else begin
      frag_eff = frag_mode;
      need_hdr = frag_mode && (packet_fill == '0);
      pf_eff   = need_hdr ? FU_BYTES : packet_fill;
      bl_eff   = bytes_left;
    end
  end

  assign total    = TOTAL_W'(pf_eff) + TOTAL_W'(bl_eff);
  assign last     = total <= limit_tot;
  assign len      = last ? total[LEN_W-1:0] : limit;
  assign pkt_end  = ({1'b0, pf_eff} + LEN_W'(1)) >= len;
  assign ind_val  = frag_start ? ((in_item.data_byte & NRI_MASK) | FU_A_TYPE) : fu_indicator;
  assign hdr_base = frag_start ? (START_BIT | (in_item.data_byte & TYPE_MASK)) : fu_header;

  always_comb begin
    q_entry.has_hdr    = need_hdr;
    q_entry.has_data   = !frag_start;
    q_entry.fu_ind     = ind_val;
    q_entry.fu_hdr     = hdr_base | (last ? END_BIT : 8'h00);
    q_entry.data       = in_item.data_byte;
    q_entry.data_start = (pf_eff == '0);
    q_entry.data_end   = pkt_end;
    q_entry.frame_end  = last;
    q_entry.len        = len;
    q_entry.channel    = in_item.channel;
    q_entry.frame_type = in_item.frame_type;
    q_entry.timestamp  = in_item.timestamp;
  end

  assign q_push = accept && produce;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload  <= MAX_PAYLOAD_RESET;
      frag_mode    <= 1'b0;
      bytes_left   <= '0;
      packet_fill  <= '0;
      fu_indicator <= '0;
      fu_header    <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_payload <= cfg_wr_data;
      end
      if (accept && produce) begin
        if (frag_start) begin
          frag_mode    <= 1'b1;
          fu_indicator <= ind_val;
          fu_header    <= hdr_base;
          bytes_left   <= bl_eff;
          packet_fill  <= FU_BYTES;
        end else begin
          if (in_item.first_of_frame) begin
            frag_mode <= 1'b0;
          end
          packet_fill <= pkt_end ? '0 : pf_eff + FILL_W'(1);
          bytes_left  <= (pkt_end && last) ? '0 : bl_eff - FRAME_SIZE_BITS'(1);
          if (pkt_end && frag_eff) begin
            fu_header <= fu_header & START_KEEP;
          end
        end
      end
    end
  end

endmodule

// ===== design/h264fu_queue.sv =====
`timescale 1ns / 1ps

module h264fu_queue #(
  parameter int DEPTH = h264fu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  h264fu_pkg::entry_t push_entry,
  output logic               full,
  output logic               not_empty,
  output h264fu_pkg::entry_t head,
  input  logic               pop
);
  import h264fu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/h264fu_back.sv =====
`timescale 1ns / 1ps

module h264fu_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_not_empty,
  input  h264fu_pkg::entry_t    q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output h264fu_pkg::out_item_t out_item
);
  import h264fu_pkg::*;

  localparam logic [1:0] SLOT_IND  = 2'd0;
  localparam logic [1:0] SLOT_HDR  = 2'd1;
  localparam logic [1:0] SLOT_DATA = 2'd2;

  logic [1:0] slot;
  logic [1:0] last_slot;
  logic       load;
  out_item_t  item_next;

  always_comb begin
    if (q_head.has_hdr) begin
      last_slot = q_head.has_data ? SLOT_DATA : SLOT_HDR;
    end else begin
      last_slot = SLOT_IND;
    end
  end

  // output register is free or being emptied this cycle
  assign load  = q_not_empty && (!out_valid || !out_stall);
  assign q_pop = load && (slot == last_slot);

  always_comb begin
    item_next.frame_end      = q_head.frame_end;
    item_next.payload_length = q_head.len;
    item_next.out_channel    = q_head.channel;
    item_next.out_type       = q_head.frame_type;
    item_next.out_timestamp  = q_head.timestamp;
    if (q_head.has_hdr && slot == SLOT_IND) begin
      item_next.out_byte     = q_head.fu_ind;
      item_next.packet_start = 1'b1;
      item_next.packet_end   = 1'b0;
    end else if (q_head.has_hdr && slot == SLOT_HDR) begin
      item_next.out_byte     = q_head.fu_hdr;
      item_next.packet_start = 1'b0;
      item_next.packet_end   = 1'b0;
    end else begin
      item_next.out_byte     = q_head.data;
      item_next.packet_start = q_head.data_start;
      item_next.packet_end   = q_head.data_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      slot      <= SLOT_IND;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        slot      <= q_pop ? SLOT_IND : slot + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== design/h264fu_checker.sv =====
`timescale 1ns / 1ps

module h264fu_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_stall,
  input h264fu_pkg::out_item_t out_item
);
  import h264fu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output transaction changed while stalled");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.payload_length != '0 &&
                  out_item.payload_length <= MAX_PAYLOAD_MAX)
    else $error("payload length out of range");

  a_single_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.packet_start && out_item.packet_end |->
      out_item.payload_length == LEN_W'(1))
    else $error("one-byte packet with wrong length");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind h264_fu_a_packetizer_core h264fu_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== bench/h264_fu_a_packet_checker.sv =====
`timescale 1ns / 1ps

module h264_fu_a_packet_checker
  import h264fu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_item,
  input  logic                 cfg_wr_en,
  input  logic [LEN_W-1:0]     cfg_wr_data,
  output int                   fail_count,
  output int                   bytes_owed
);

  logic [LEN_W-1:0] payload_reg;
  bit               fragmenting;
  int unsigned      left_bytes;
  int unsigned      fill;
  logic [7:0]       fu_ind_q;
  logic [7:0]       fu_hdr_q;
  out_item_t        expected_bytes[$];

  task automatic queue_byte(input logic [7:0] b, input bit ps, input bit pe, input bit fe,
                            input int unsigned len, input in_item_t it);
    out_item_t o;
    o.out_byte       = b;
    o.packet_start   = ps;
    o.packet_end     = pe;
    o.frame_end      = fe;
    o.payload_length = LEN_W'(len);
    o.out_channel    = it.channel;
    o.out_type       = it.frame_type;
    o.out_timestamp  = it.timestamp;
    expected_bytes.push_back(o);
  endtask

  // fu indicator and fu header that open every fragment packet
  task automatic queue_fu_pair(input int unsigned lim, input in_item_t it);
    int unsigned total;
    int unsigned len;
    bit          last;
    total = fill + left_bytes;
    len   = (total < lim) ? total : lim;
    last  = (total <= lim);
    queue_byte(fu_ind_q, 1'b1, 1'b0, last, len, it);
    queue_byte(fu_hdr_q | (last ? END_BIT : 8'h00), 1'b0, 1'b0, last, len, it);
  endtask

  task automatic packetize_byte(input in_item_t it);
    int unsigned lim;
    int unsigned f;
    int unsigned total;
    int unsigned len;
    bit          last;
    bit          end_pkt;
    lim = (payload_reg < MAX_PAYLOAD_MIN) ? 32'(MAX_PAYLOAD_MIN) :
          (payload_reg > MAX_PAYLOAD_MAX) ? 32'(MAX_PAYLOAD_MAX) : 32'(payload_reg);
    if (it.first_of_frame) begin
      f = 32'(it.frame_size);
      if (f == 0) f = 1;
      fill = 0;
      if (f <= lim) begin
        fragmenting = 1'b0;
        left_bytes  = f;
      end else begin
        // nal header byte is consumed into the fu bytes
        fragmenting = 1'b1;
        fu_ind_q    = (it.data_byte & NRI_MASK) | FU_A_TYPE;
        fu_hdr_q    = START_BIT | (it.data_byte & TYPE_MASK);
        left_bytes  = f - 1;
        fill        = 2;
        queue_fu_pair(lim, it);
        return;
      end
    end else if (left_bytes == 0) begin
      return;
    end

    if (fragmenting && fill == 0) begin
      fill = 2;
      queue_fu_pair(lim, it);
    end

    total   = fill + left_bytes;
    len     = (total < lim) ? total : lim;
    last    = (total <= lim);
    end_pkt = (fill + 1 >= len);
    queue_byte(it.data_byte, fill == 0, end_pkt, last, len, it);
    fill++;
    left_bytes--;
    if (end_pkt) begin
      fill = 0;
      if (fragmenting) fu_hdr_q = fu_hdr_q & START_KEEP;
      if (last) left_bytes = 0;
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      payload_reg = MAX_PAYLOAD_RESET;
      fragmenting = 1'b0;
      left_bytes  = 0;
      fill        = 0;
      fu_ind_q    = '0;
      fu_hdr_q    = '0;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte expected none actual %0h", out_item.out_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("out_byte", 32'(want.out_byte), 32'(out_item.out_byte));
          check_field("packet_start", 32'(want.packet_start),
                      32'(out_item.packet_start));
          check_field("packet_end", 32'(want.packet_end), 32'(out_item.packet_end));
          check_field("frame_end", 32'(want.frame_end), 32'(out_item.frame_end));
          check_field("payload_length", 32'(want.payload_length),
                      32'(out_item.payload_length));
          check_field("out_channel", 32'(want.out_channel), 32'(out_item.out_channel));
          check_field("out_type", 32'(want.out_type), 32'(out_item.out_type));
          check_field("out_timestamp", want.out_timestamp, out_item.out_timestamp);
        end
      end
      if (cfg_wr_en) payload_reg = cfg_wr_data;
      if (in_valid && !in_stall) packetize_byte(in_item);
    end
    bytes_owed = expected_bytes.size();
  end

endmodule

// ===== bench/h264_fu_a_packetizer_core_tb.sv =====
`timescale 1ns / 1ps

module h264_fu_a_packetizer_core_tb;
  import h264fu_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int PHASE_ITEMS  = 28;
  localparam int HOLDOFF_AT   = 150;
  localparam int HOLDOFF_LEN  = 300;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_item_t         in_item     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_item_t        out_item;
  logic             cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;

  int               fail_count;
  int               bytes_owed;
  int               quiet_cycles = 0;
  int               bytes_sent   = 0;
  bit               burst_mode   = 1'b0;
  int unsigned      eff_limit    = 32'(MAX_PAYLOAD_RESET);
  logic [7:0]       cur_chan;
  logic [7:0]       cur_type;
  logic [31:0]      cur_ts;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  h264_fu_a_packetizer_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  h264_fu_a_packet_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .bytes_owed  (bytes_owed)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high from one transaction to the next when there is no gap
  task automatic offer_byte(input in_item_t it);
    int gap;
    if (bytes_sent % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
    bytes_sent++;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_nal_bytes(input bit starts, input logic [23:0] declared,
                                input int count, input logic [7:0] nal_hdr);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it.data_byte      = (starts && i == 0) ? nal_hdr : 8'($urandom);
      it.first_of_frame = starts && (i == 0);
      it.frame_size     = (i == 0) ? declared : 24'($urandom);
      it.channel        = cur_chan;
      it.frame_type     = cur_type;
      it.timestamp      = cur_ts;
      offer_byte(it);
    end
  endtask

  // block must be drained before the register changes
  task automatic set_payload_limit(input logic [LEN_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (bytes_owed == 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    eff_limit = (v < MAX_PAYLOAD_MIN) ? 32'(MAX_PAYLOAD_MIN) :
                (v > MAX_PAYLOAD_MAX) ? 32'(MAX_PAYLOAD_MAX) : 32'(v);
  endtask

  initial begin
    int n;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (taken % 50 == 0) calm = ($urandom_range(0, 2) == 0);
        n = calm ? 0 : $urandom_range(0, 17);
        // long hold-off so the queue fills and the input stalls
        if (taken == HOLDOFF_AT) n = HOLDOFF_LEN;
        taken++;
        if (n != 0) begin
          @(negedge clk);
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    logic [LEN_W-1:0] limits[12];
    int               phase_items;
    int               kind;
    int               span;
    int               len;
    int               cut;
    limits = '{14'd0, 14'd8192, 14'd4, 14'd16383, 14'd7, 14'd2,
               14'd9000, 14'd1400, 14'd5, 14'd3, 14'd12, 14'd33};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single byte frame, all fields high
    cur_chan = 8'hFF;
    cur_type = 8'hFF;
    cur_ts   = 32'hFFFF_FFFF;
    send_nal_bytes(1'b1, 24'd1, 1, 8'hFF);
    // zero frame size acts as one byte
    cur_chan = 8'h00;
    cur_type = 8'h00;
    cur_ts   = 32'h0;
    send_nal_bytes(1'b1, 24'd0, 1, 8'h00);
    // stray byte past the frame end
    send_nal_bytes(1'b0, 24'd5, 1, 8'h00);
    // huge frame starts fragmenting, then gets abandoned
    cur_chan = 8'($urandom);
    cur_type = 8'($urandom);
    cur_ts   = $urandom;
    send_nal_bytes(1'b1, 24'hFF_FFFF, 2, 8'h65);
    send_nal_bytes(1'b1, 24'd3, 3, 8'h41);

    set_payload_limit(14'd3);
    send_nal_bytes(1'b1, 24'd4, 4, 8'hFF);
    send_nal_bytes(1'b1, 24'd3, 3, 8'h00);

    // limit lowered mid-frame below the current packet fill
    set_payload_limit(14'd6);
    send_nal_bytes(1'b1, 24'd10, 4, 8'h7C);
    set_payload_limit(14'd3);
    send_nal_bytes(1'b0, 24'd0, 6, 8'h00);

    foreach (limits[p]) begin
      set_payload_limit(limits[p]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        kind     = $urandom_range(0, 19);
        cur_chan = 8'($urandom);
        cur_type = 8'($urandom);
        cur_ts   = $urandom;
        span     = (eff_limit * 3 < 40) ? eff_limit * 3 : 40;
        len      = $urandom_range(1, span);
        if (eff_limit <= 64 && kind == 0) len = eff_limit;
        if (eff_limit <= 64 && kind == 1) len = eff_limit + 1;
        if (kind < 14) begin
          send_nal_bytes(1'b1, 24'(len), len, 8'($urandom));
          phase_items += len;
        end else if (kind < 16) begin
          cut = $urandom_range(1, len);
          send_nal_bytes(1'b1, 24'(len), cut, 8'($urandom));
          phase_items += cut;
        end else if (kind == 16) begin
          send_nal_bytes(1'b1, 24'd0, 1, 8'($urandom));
          phase_items += 1;
        end else if (kind == 17) begin
          cut = $urandom_range(1, 6);
          send_nal_bytes(1'b1, 24'($urandom), cut, 8'($urandom));
          phase_items += cut;
        end else begin
          // noise: bytes with no frame start
          send_nal_bytes(1'b0, 24'($urandom), $urandom_range(1, 3), 8'($urandom));
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (bytes_owed == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
